FILE: design/searchable_stack_macros.svh
// assertion macros for the searchable stack
// used by searchable_stack.sv; expects aclk and aresetn in scope
`ifndef SEARCHABLE_STACK_MACROS_SVH
`define SEARCHABLE_STACK_MACROS_SVH

// same-cycle implication
`define SS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("searchable_stack: same-cycle check failed");

// next-cycle implication
`define SS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("searchable_stack: next-cycle check failed");

`endif

FILE: design/ss_pkg.sv
// shared types and constants of the searchable stack
// no dependencies; imported by ss_cell and searchable_stack
package ss_pkg;

    localparam int SS_DEPTH   = 64;
    localparam int SS_WORD_W  = 32;
    localparam int SS_INDEX_W = 6;
    localparam int SS_IN_W    = 32;
    localparam int SS_OUT_W   = 40;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_LIST   = 2'd3
    } ss_action_t;

    typedef enum logic [2:0] {
        STAT_PUSHED   = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_DELETED  = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FOUND    = 3'd4,
        STAT_LISTED   = 3'd5,
        STAT_EMPTY    = 3'd6
    } ss_status_t;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_PUSH    = 3'd1,
        OP_CAPTURE = 3'd2,
        OP_SCAN    = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_ROTATE  = 3'd5
    } ss_op_t;

    typedef struct packed {
        ss_op_t                 op;
        logic [SS_WORD_W-1:0]   value;
    } ss_cmd_t;

endpackage

FILE: design/ss_cell.sv
// one stack cell: a stored word and a match flag, position IDX from the top
// depends on ss_pkg; instantiated in a row by searchable_stack
module ss_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                           aclk,
    input  ss_pkg::ss_cmd_t                cmd,
    input  logic [CW-1:0]                  count,
    input  logic [CW-1:0]                  pos,
    input  logic [ss_pkg::SS_WORD_W-1:0]   prev_data,
    input  logic [ss_pkg::SS_WORD_W-1:0]   next_data,
    input  logic [ss_pkg::SS_WORD_W-1:0]   wrap_data,
    input  logic                           next_hit,
    output logic [ss_pkg::SS_WORD_W-1:0]   data,
    output logic                           hit
);
    import ss_pkg::*;

    localparam logic [CW-1:0] IDX_V  = CW'(IDX);
    localparam logic [CW-1:0] IDX1_V = CW'(IDX + 1);

    logic [SS_WORD_W-1:0] data_reg, data_next;
    logic                 hit_reg, hit_next;

    always_comb begin
        data_next = data_reg;
        hit_next  = hit_reg;
        unique case (cmd.op)
            OP_PUSH: begin
                data_next = prev_data;
            end
            OP_CAPTURE: begin
                hit_next = (IDX_V < count) && (data_reg == cmd.value);
            end
            OP_SCAN: begin
                hit_next = next_hit;
            end
            OP_REMOVE: begin
                if (IDX_V >= pos) begin
                    data_next = next_data;
                end
            end
            OP_ROTATE: begin
                if (IDX1_V < count) begin
                    data_next = next_data;
                end else if (IDX1_V == count) begin
                    data_next = wrap_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

FILE: design/searchable_stack.sv
// searchable stack top: command sequencer, output register and the cell row
// depends on ss_pkg, ss_cell and searchable_stack_macros.svh
//
//  channel | dir | ports                               | payload
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser   | value, action
//  m_      | out | m_tvalid m_tready m_tdata m_tuser   | index, data, status; m_tlast
//
// push: one result; find, find and delete: a capture compares each filled cell,
// then hit flags shift up until cell 0 hits or the scan covers the fill; list: words
// rotate up, top wrapping to bottom (empty: STAT_EMPTY); one cell a cycle unless stalled
// synchronous active-low reset empties the stack, stored words keep no reset
// a stalled result port holds the sequencer; a new transfer waits for idle
`include "searchable_stack_macros.svh"

module searchable_stack #(
    parameter int DEPTH = ss_pkg::SS_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ss_pkg::SS_IN_W-1:0]    s_tdata,   // [31:0] value
    input  logic [1:0]                    s_tuser,   // [1:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ss_pkg::SS_OUT_W-1:0]   m_tdata,   // [5:0] index, [37:6] data, [39:38] zero
    output logic [2:0]                    m_tuser,   // [2:0] status
    output logic                          m_tlast
);
    import ss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        step_reg, step_next;
    ss_action_t           act_reg, act_next;
    logic [SS_WORD_W-1:0] val_reg, val_next;

    logic                 out_valid_reg, out_valid_next;
    ss_status_t           out_status_reg, out_status_next;
    logic [SS_INDEX_W-1:0] out_index_reg, out_index_next;
    logic [SS_WORD_W-1:0] out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    ss_cmd_t              cmd;
    logic                 out_free;
    logic                 in_fire;
    logic [CW-1:0]        rank;
    logic [SS_WORD_W-1:0] cell_data [DEPTH];
    logic                 cell_hit  [DEPTH];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign rank     = fill_reg - step_reg - CW'(1);

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        step_next       = step_reg;
        act_next        = act_reg;
        val_next        = val_reg;
        cmd.op          = OP_HOLD;
        cmd.value       = s_tdata;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (ss_action_t'(s_tuser))
                        ACT_PUSH: begin
                            out_valid_next = 1'b1;
                            out_index_next = '0;
                            out_data_next  = s_tdata;
                            out_last_next  = 1'b1;
                            if (fill_reg != CW'(DEPTH)) begin
                                cmd.op          = OP_PUSH;
                                fill_next       = fill_reg + CW'(1);
                                out_status_next = STAT_PUSHED;
                            end else begin
                                out_status_next = STAT_FULL;
                            end
                        end
                        ACT_DELETE, ACT_FIND: begin
                            cmd.op     = OP_CAPTURE;
                            act_next   = ss_action_t'(s_tuser);
                            val_next   = s_tdata;
                            step_next  = '0;
                            state_next = S_SCAN;
                        end
                        ACT_LIST: begin
                            if (fill_reg == '0) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_EMPTY;
                                out_index_next  = '0;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end else begin
                                step_next  = '0;
                                state_next = S_LIST;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.value = val_reg;
                if (cell_hit[0]) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_data_next  = val_reg;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                        if (act_reg == ACT_DELETE) begin
                            cmd.op          = OP_REMOVE;
                            fill_next       = fill_reg - CW'(1);
                            out_status_next = STAT_DELETED;
                            out_index_next  = '0;
                        end else begin
                            out_status_next = STAT_FOUND;
                            out_index_next  = SS_INDEX_W'(rank);
                        end
                    end
                end else if (step_reg == fill_reg) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_NOTFOUND;
                        out_index_next  = '0;
                        out_data_next   = val_reg;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.op    = OP_SCAN;
                    step_next = step_reg + CW'(1);
                end
            end
            S_LIST: begin
                cmd.value = val_reg;
                if (out_free) begin
                    cmd.op          = OP_ROTATE;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_LISTED;
                    out_index_next  = SS_INDEX_W'(rank);
                    out_data_next   = cell_data[0];
                    out_last_next   = (step_reg + CW'(1)) == fill_reg;
                    step_next       = step_reg + CW'(1);
                    if ((step_reg + CW'(1)) == fill_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        val_reg        <= val_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    // cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [SS_WORD_W-1:0] prev_w;
        logic [SS_WORD_W-1:0] next_w;
        logic                 next_h;

        if (i == 0) begin : g_top
            assign prev_w = cmd.value;
        end else begin : g_mid
            assign prev_w = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign next_w = cell_data[i];
            assign next_h = 1'b0;
        end else begin : g_above
            assign next_w = cell_data[i+1];
            assign next_h = cell_hit[i+1];
        end

        ss_cell #(
            .DEPTH (DEPTH),
            .IDX   (i),
            .CW    (CW)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .count     (fill_reg),
            .pos       (step_reg),
            .prev_data (prev_w),
            .next_data (next_w),
            .wrap_data (cell_data[0]),
            .next_hit  (next_h),
            .data      (cell_data[i]),
            .hit       (cell_hit[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg, out_index_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `SS_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH))
    `SS_ASSERT_NEXT(a_push_grows,
        in_fire && s_tuser == ACT_PUSH && fill_reg != CW'(DEPTH),
        fill_reg == $past(fill_reg) + CW'(1))
    `SS_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, step_reg <= fill_reg)
    `SS_ASSERT_IMP(a_list_bottom, m_tvalid && m_tlast && m_tuser == STAT_LISTED, m_tdata[5:0] == 6'd0)

endmodule
